[rtl/qwo_pkg.sv]
// Shared types, constants and helpers for the quadrature wheel odometer.
`timescale 1ns / 1ps
`default_nettype none
package qwo_pkg;

    // Field and state widths
    localparam int CNT_W          = 32;
    localparam int DLT_W          = 16;
    localparam int DIST_W         = 64;
    localparam int SCALE_W        = 32;
    localparam int OUT_WHEELS     = 4;
    localparam int NUM_WHEELS_DEF = 4;
    localparam int Q_DEPTH        = 4;
    localparam int Q_PTR_W        = $clog2(Q_DEPTH);

    // Event kinds carried in tuser; code 3 is unused and ignored
    typedef enum logic [1:0] {
        FUNC_EDGE = 2'd0,
        FUNC_TICK = 2'd1,
        FUNC_CLR  = 2'd2
    } t_func;

    // Command kinds that travel from front to back
    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_CLR  = 1'b1
    } t_cmd_kind;

    // Push request from the front into the queue
    typedef struct packed {
        logic      valid;
        t_cmd_kind kind;
    } t_q_push;

    // Head of the queue as seen by the back
    typedef struct packed {
        logic      valid;
        t_cmd_kind kind;
    } t_q_head;

    // Wrapping count difference, saturated to signed 16 bits
    function automatic logic [DLT_W-1:0] sat_delta(input logic [CNT_W-1:0] now,
                                                   input logic [CNT_W-1:0] prev);
        logic [CNT_W-1:0] d;
        logic [DLT_W-1:0] r;
        d = now - prev;
        if (!d[CNT_W-1] && (d[CNT_W-2:DLT_W-1] != '0)) begin
            r = {1'b0, {(DLT_W-1){1'b1}}};
        end else if (d[CNT_W-1] && (d[CNT_W-2:DLT_W-1] != '1)) begin
            r = {1'b1, {(DLT_W-1){1'b0}}};
        end else begin
            r = d[DLT_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/qwo_front.sv]
// Front end: tick counters per wheel, snapshots and saturated deltas on control ticks.
`timescale 1ns / 1ps
`default_nettype none
module qwo_front #(
    parameter int NUM_WHEELS = qwo_pkg::NUM_WHEELS_DEF
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire                                     i_accept,
    input  wire  [1:0]                              i_func,
    input  wire  [1:0]                              i_wheel,
    input  wire                                     i_edge_channel,
    input  wire                                     i_other_level,
    output qwo_pkg::t_q_push                        o_push,
    output logic [NUM_WHEELS*qwo_pkg::DLT_W-1:0]    o_dlt
);

    localparam int CW = qwo_pkg::CNT_W;
    localparam int DW = qwo_pkg::DLT_W;

    logic [CW-1:0] r_cnt  [NUM_WHEELS];
    logic [CW-1:0] r_snap [NUM_WHEELS];
    qwo_pkg::t_func func;
    logic is_edge;
    logic is_tick;
    logic up;

    // Decode the request
    always_comb begin
        func    = qwo_pkg::t_func'(i_func);
        is_edge = 1'b0;
        is_tick = 1'b0;
        o_push  = '0;
        case (func)
            qwo_pkg::FUNC_EDGE: begin
                is_edge = i_accept;
            end
            qwo_pkg::FUNC_TICK: begin
                is_tick       = i_accept;
                o_push.valid  = i_accept;
                o_push.kind   = qwo_pkg::CMD_TICK;
            end
            qwo_pkg::FUNC_CLR: begin
                o_push.valid  = i_accept;
                o_push.kind   = qwo_pkg::CMD_CLR;
            end
            default: begin
                o_push = '0;
            end
        endcase
        // channel A counts up with B high, channel B the reverse
        up = i_edge_channel ^ i_other_level;
    end

    // Deltas since the last control tick
    always_comb begin
        for (int i = 0; i < NUM_WHEELS; i++) begin
            o_dlt[i*DW +: DW] = qwo_pkg::sat_delta(r_cnt[i], r_snap[i]);
        end
    end

    // Counters and snapshots; wheels past the count never match
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_WHEELS; i++) begin
                r_cnt[i]  <= '0;
                r_snap[i] <= '0;
            end
        end else begin
            for (int i = 0; i < NUM_WHEELS; i++) begin
                if (is_edge && (32'(i_wheel) == 32'(i))) begin
                    r_cnt[i] <= r_cnt[i] + (up ? CW'(1) : {CW{1'b1}});
                end
                if (is_tick) begin
                    r_snap[i] <= r_cnt[i];
                end
            end
        end
    end

endmodule
`default_nettype wire

[rtl/qwo_cmd_fifo.sv]
// Short command queue between the front and the back.
`timescale 1ns / 1ps
`default_nettype none
module qwo_cmd_fifo #(
    parameter int NUM_WHEELS = qwo_pkg::NUM_WHEELS_DEF
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  qwo_pkg::t_q_push                        i_push,
    input  wire  [NUM_WHEELS*qwo_pkg::DLT_W-1:0]    i_dlt,
    input  wire                                     i_pop,
    output qwo_pkg::t_q_head                        o_head,
    output logic [NUM_WHEELS*qwo_pkg::DLT_W-1:0]    o_dlt,
    output logic                                    o_full
);

    localparam int DEPTH = qwo_pkg::Q_DEPTH;
    localparam int PW    = qwo_pkg::Q_PTR_W;
    localparam int EW    = NUM_WHEELS * qwo_pkg::DLT_W;

    logic [EW-1:0]            r_dlt  [DEPTH];
    qwo_pkg::t_cmd_kind       r_kind [DEPTH];
    logic [PW-1:0]            r_wr, n_wr;
    logic [PW-1:0]            r_rd, n_rd;
    logic [PW:0]              r_cnt, n_cnt;
    logic                     do_pop;

    // Head and status
    always_comb begin
        o_head.valid = (r_cnt != '0);
        o_head.kind  = r_kind[r_rd];
        o_dlt        = r_dlt[r_rd];
        o_full       = (r_cnt == (PW+1)'(DEPTH));
        do_pop       = i_pop && o_head.valid;
        n_wr         = i_push.valid ? r_wr + PW'(1) : r_wr;
        n_rd         = do_pop ? r_rd + PW'(1) : r_rd;
        n_cnt        = r_cnt + (PW+1)'(i_push.valid) - (PW+1)'(do_pop);
    end

    // Pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_dlt[r_wr]  <= i_dlt;
            r_kind[r_wr] <= i_push.kind;
        end
    end

endmodule
`default_nettype wire

[rtl/qwo_back.sv]
// Back end: delta sum, scale multiply and saturating distance accumulation.
`timescale 1ns / 1ps
`default_nettype none
module qwo_back #(
    parameter int NUM_WHEELS = qwo_pkg::NUM_WHEELS_DEF
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  qwo_pkg::t_q_head                        i_head,
    input  wire  [NUM_WHEELS*qwo_pkg::DLT_W-1:0]    i_dlt,
    output logic                                    o_pop,
    input  wire  [qwo_pkg::SCALE_W-1:0]             i_scale,
    output logic                                    o_valid,
    input  wire                                     i_ready,
    output logic [qwo_pkg::DIST_W-1:0]              o_distance,
    output logic [qwo_pkg::OUT_WHEELS*qwo_pkg::DLT_W-1:0] o_dlt
);

    localparam int DW     = qwo_pkg::DLT_W;
    localparam int XW     = qwo_pkg::DIST_W;
    localparam int OW     = qwo_pkg::OUT_WHEELS * DW;
    localparam int SUM_W  = DW + $clog2(NUM_WHEELS);
    localparam int PROD_W = SUM_W + qwo_pkg::SCALE_W + 1;

    logic                      advance;
    logic [OW-1:0]             q_out_dlt;
    logic signed [SUM_W-1:0]   n_sum;

    logic                      r_s1_valid;
    qwo_pkg::t_cmd_kind        r_s1_kind;
    logic signed [SUM_W-1:0]   r_s1_sum;
    logic [OW-1:0]             r_s1_dlt;

    logic                      r_s2_valid;
    qwo_pkg::t_cmd_kind        r_s2_kind;
    logic signed [PROD_W-1:0]  r_s2_prod;
    logic [OW-1:0]             r_s2_dlt;

    logic signed [XW-1:0]      r_acc;
    logic signed [XW:0]        acc_sum;
    logic signed [XW-1:0]      n_acc;
    logic                      r_out_valid;
    logic [XW-1:0]             r_out_dist;
    logic [OW-1:0]             r_out_dlt;

    // Whole pipe moves when the output slot is free or being taken
    assign advance = !r_out_valid || i_ready;
    assign o_pop   = advance && i_head.valid;

    // Sum of all wheel deltas
    always_comb begin
        n_sum = '0;
        for (int i = 0; i < NUM_WHEELS; i++) begin
            n_sum = n_sum + SUM_W'($signed(i_dlt[i*DW +: DW]));
        end
    end

    // Output deltas; wheels missing under the parameter read zero
    for (genvar k = 0; k < qwo_pkg::OUT_WHEELS; k++) begin : g_out
        if (k < NUM_WHEELS) begin : g_have
            assign q_out_dlt[k*DW +: DW] = i_dlt[k*DW +: DW];
        end else begin : g_zero
            assign q_out_dlt[k*DW +: DW] = '0;
        end
    end

    // Saturating accumulate
    always_comb begin
        acc_sum = (XW+1)'(r_acc) + (XW+1)'(r_s2_prod);
        if (acc_sum[XW] != acc_sum[XW-1]) begin
            n_acc = acc_sum[XW] ? {1'b1, {(XW-1){1'b0}}} : {1'b0, {(XW-1){1'b1}}};
        end else begin
            n_acc = acc_sum[XW-1:0];
        end
    end

    // Stage valids and accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_acc       <= '0;
        end else if (advance) begin
            r_s1_valid  <= i_head.valid;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid && (r_s2_kind == qwo_pkg::CMD_TICK);
            if (r_s2_valid) begin
                if (r_s2_kind == qwo_pkg::CMD_TICK) begin
                    r_acc <= n_acc;
                end else begin
                    r_acc <= '0;
                end
            end
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_kind  <= i_head.kind;
            r_s1_sum   <= n_sum;
            r_s1_dlt   <= q_out_dlt;
            r_s2_kind  <= r_s1_kind;
            r_s2_prod  <= PROD_W'(r_s1_sum) * PROD_W'($signed({1'b0, i_scale}));
            r_s2_dlt   <= r_s1_dlt;
            r_out_dist <= n_acc;
            r_out_dlt  <= r_s2_dlt;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_distance = r_out_dist;
    assign o_dlt      = r_out_dlt;

endmodule
`default_nettype wire

[rtl/quadrature_wheel_odometer.sv]
// Top level of the four-wheel quadrature odometer.
//
//  channel | direction | handshake                     | payload
//  --------+-----------+-------------------------------+-------------------------------
//  s_axis  | in        | s_axis_tvalid / s_axis_tready | tuser func, tdata edge info
//  m_axis  | out       | m_axis_tvalid / m_axis_tready | distance and four wheel deltas
//  cfg     | in        | i_cfg_valid / o_cfg_ready     | distance per tick, 32 bits
//
// One request is taken every cycle; ready drops only while the four-entry command
// queue is full. Edge events update the counter registers when taken; a control
// tick is written into the queue when taken and passes through the sum, multiply
// and accumulate stages to the output register. The back pipeline holds while a
// result waits on m_axis.
// Reset is synchronous active low and clears counters, snapshots, distance
// and the scale register.
`timescale 1ns / 1ps
`default_nettype none
module quadrature_wheel_odometer #(
    parameter int NUM_WHEELS = qwo_pkg::NUM_WHEELS_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [7:0]   s_axis_tdata,   // wheel[1:0], edge_channel[2], other_level[3], zero pad
    input  wire  [1:0]   s_axis_tuser,   // func[1:0]
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [127:0] m_axis_tdata,   // distance[63:0], delta_wheel0..3 at [79:64] upward
    input  wire          i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire  [31:0]  i_cfg_data
);

    localparam int EW = NUM_WHEELS * qwo_pkg::DLT_W;

    logic                       accept;
    logic                       q_full;
    logic                       pop;
    qwo_pkg::t_q_push           push;
    qwo_pkg::t_q_head           head;
    logic [EW-1:0]              front_dlt;
    logic [EW-1:0]              head_dlt;
    logic [qwo_pkg::SCALE_W-1:0] r_scale;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // Scale register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= '0;
        end else if (i_cfg_valid) begin
            r_scale <= i_cfg_data;
        end
    end

    qwo_front #(.NUM_WHEELS(NUM_WHEELS)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_func         (s_axis_tuser),
        .i_wheel        (s_axis_tdata[1:0]),
        .i_edge_channel (s_axis_tdata[2]),
        .i_other_level  (s_axis_tdata[3]),
        .o_push         (push),
        .o_dlt          (front_dlt)
    );

    qwo_cmd_fifo #(.NUM_WHEELS(NUM_WHEELS)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_dlt   (front_dlt),
        .i_pop   (pop),
        .o_head  (head),
        .o_dlt   (head_dlt),
        .o_full  (q_full)
    );

    qwo_back #(.NUM_WHEELS(NUM_WHEELS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_dlt      (head_dlt),
        .o_pop      (pop),
        .i_scale    (r_scale),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_distance (m_axis_tdata[63:0]),
        .o_dlt      (m_axis_tdata[127:64])
    );

endmodule
`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the quadrature wheel odometer.
`timescale 1ns / 1ps
module testbench;

    localparam int          NWHEEL      = 4;
    localparam logic [1:0]  FUNC_UNUSED = 2'd3;
    localparam int          CYCLE_LIMIT = 100_000;
    localparam int          LONG_HOLD   = 300;
    localparam int          SETTLE      = 16;

    // One input request as the block sees it
    typedef struct packed {
        logic [1:0] func;
        logic [1:0] wheel;
        logic       chan;
        logic       other;
    } t_odo_event;

    // One result, laid out as m_axis_tdata
    typedef struct packed {
        logic [15:0] dw3;
        logic [15:0] dw2;
        logic [15:0] dw1;
        logic [15:0] dw0;
        logic [63:0] distance;
    } t_odo_result;

    logic         i_clk          = 1'b0;
    logic         i_rst_n        = 1'b0;
    logic         s_axis_tvalid  = 1'b0;
    logic [7:0]   s_axis_tdata   = '0;   // wheel[1:0], edge_channel[2], other_level[3], pad
    logic [1:0]   s_axis_tuser   = '0;   // func[1:0]
    logic         m_axis_tready  = 1'b0;
    logic         i_cfg_valid    = 1'b0;
    logic [31:0]  i_cfg_data     = '0;
    logic         s_axis_tready;
    logic         m_axis_tvalid;
    logic [127:0] m_axis_tdata;          // distance[63:0], delta_wheel0..3 from bit 64 up
    logic         o_cfg_ready;

    quadrature_wheel_odometer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // Clock, 8 ns period
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Odometer model state
    logic [31:0]        tick_cnt [NWHEEL];
    logic [31:0]        tick_snap[NWHEEL];
    logic signed [63:0] dist_acc;
    logic [31:0]        dist_per_tick;

    t_odo_event  pending_events[$];
    t_odo_result odo_expected[$];
    int          events_queued = 0;
    int          events_sent   = 0;
    int          mismatches    = 0;
    bit          idle_on       = 1'b1;
    bit          long_hold_req = 1'b0;

    // Wrapping difference of two counts, clamped to signed 16 bits
    function automatic logic [15:0] clamp_delta(input logic [31:0] now,
                                                input logic [31:0] prev);
        logic signed [31:0] d;
        d = now - prev;
        if (d > 32767)
            return 16'h7FFF;
        if (d < -32768)
            return 16'h8000;
        return d[15:0];
    endfunction

    // Apply one accepted request to the model; ticks queue a result
    task automatic odo_advance(input t_odo_event ev);
        t_odo_result        res;
        logic [15:0]        dl[NWHEEL];
        logic signed [63:0] sum;
        logic signed [63:0] inc;
        logic signed [64:0] acc;
        case (ev.func)
            qwo_pkg::FUNC_EDGE: begin
                // channel A counts up with B high; channel B the reverse
                if ((ev.chan == 1'b0) ? ev.other : !ev.other)
                    tick_cnt[ev.wheel] = tick_cnt[ev.wheel] + 32'd1;
                else
                    tick_cnt[ev.wheel] = tick_cnt[ev.wheel] - 32'd1;
            end
            qwo_pkg::FUNC_CLR: begin
                dist_acc = '0;
            end
            qwo_pkg::FUNC_TICK: begin
                sum = '0;
                for (int i = 0; i < NWHEEL; i++) begin
                    dl[i]        = clamp_delta(tick_cnt[i], tick_snap[i]);
                    tick_snap[i] = tick_cnt[i];
                    sum          = sum + 64'($signed(dl[i]));
                end
                inc = sum * $signed({32'b0, dist_per_tick});
                acc = {dist_acc[63], dist_acc} + {inc[63], inc};
                // saturate on signed overflow
                if (acc[64] != acc[63])
                    dist_acc = acc[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
                else
                    dist_acc = acc[63:0];
                res.distance = dist_acc;
                res.dw0      = dl[0];
                res.dw1      = dl[1];
                res.dw2      = dl[2];
                res.dw3      = dl[3];
                odo_expected.push_back(res);
            end
            default: ;
        endcase
    endtask

    function automatic void check_field(input string name, input logic [63:0] exp_v,
                                        input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    // Request driver
    t_odo_event drv_event;
    int         src_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                odo_advance(drv_event);
                events_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_events.size() != 0) begin
                    drv_event = pending_events.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= drv_event.func;
                    s_axis_tdata  <= {4'b0, drv_event.other, drv_event.chan, drv_event.wheel};
                    if (idle_on && $urandom_range(0, 5) == 0)
                        src_gap = $urandom_range(1, 8);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stalls
    t_odo_result got;
    t_odo_result want;
    int          sink_gap  = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (odo_expected.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, m_axis_tdata);
                    mismatches++;
                end else begin
                    want = odo_expected.pop_front();
                    check_field("distance", want.distance, got.distance);
                    check_field("delta_wheel0", 64'(want.dw0), 64'(got.dw0));
                    check_field("delta_wheel1", 64'(want.dw1), 64'(got.dw1));
                    check_field("delta_wheel2", 64'(want.dw2), 64'(got.dw2));
                    check_field("delta_wheel3", 64'(want.dw3), 64'(got.dw3));
                end
            end
            // one long hold-off so the command queue fills and input stalls
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (long_hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
                m_axis_tready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                sink_gap = $urandom_range(1, 8) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog
    int cycles = 0;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic push_event(input logic [1:0] func, input logic [1:0] wheel,
                              input logic chan, input logic other);
        t_odo_event ev;
        ev.func  = func;
        ev.wheel = wheel;
        ev.chan  = chan;
        ev.other = other;
        pending_events.push_back(ev);
        events_queued++;
    endtask

    // Random mix; runs of same-direction edges build up larger deltas
    task automatic push_random(input int count);
        int         n;
        int         r;
        int         run;
        logic [1:0] w;
        logic       c;
        logic       o;
        n = 0;
        while (n < count) begin
            r = $urandom_range(0, 99);
            w = 2'($urandom_range(0, 3));
            c = 1'($urandom_range(0, 1));
            o = 1'($urandom_range(0, 1));
            if (r < 10) begin
                run = $urandom_range(5, 40);
                for (int k = 0; k < run; k++)
                    push_event(qwo_pkg::FUNC_EDGE, w, c, o);
                n += run;
            end else begin
                if (r < 70)
                    push_event(qwo_pkg::FUNC_EDGE, w, c, o);
                else if (r < 86)
                    push_event(qwo_pkg::FUNC_TICK, w, c, o);
                else if (r < 94)
                    push_event(qwo_pkg::FUNC_CLR, w, c, o);
                else
                    push_event(FUNC_UNUSED, w, c, o);
                n++;
            end
        end
    endtask

    // Wait until every request is taken and every result checked, then settle
    task automatic drain();
        do
            @(posedge i_clk);
        while (events_sent != events_queued || odo_expected.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_scale(input logic [31:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid   <= 1'b0;
        dist_per_tick  = v;
    endtask

    // Stimulus sequence
    initial begin
        for (int i = 0; i < NWHEEL; i++) begin
            tick_cnt[i]  = '0;
            tick_snap[i] = '0;
        end
        dist_acc      = '0;
        dist_per_tick = '0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed: every channel/level pair, each wheel, all event kinds
        write_scale(32'hFFFF_FFFF);
        for (int k = 0; k < 8; k++)
            push_event(qwo_pkg::FUNC_EDGE, k[1:0], k[2], k[0] ^ k[1]);
        push_event(qwo_pkg::FUNC_TICK, 2'd0, 1'b0, 1'b0);
        push_event(FUNC_UNUSED, 2'd3, 1'b1, 1'b1);
        push_event(qwo_pkg::FUNC_TICK, 2'd3, 1'b1, 1'b1);
        push_event(qwo_pkg::FUNC_CLR, 2'd0, 1'b0, 1'b0);
        push_event(qwo_pkg::FUNC_TICK, 2'd0, 1'b0, 1'b0);
        push_event(qwo_pkg::FUNC_EDGE, 2'd3, 1'b0, 1'b0);
        push_event(qwo_pkg::FUNC_EDGE, 2'd3, 1'b1, 1'b1);
        push_event(qwo_pkg::FUNC_EDGE, 2'd1, 1'b1, 1'b0);
        push_event(qwo_pkg::FUNC_TICK, 2'd2, 1'b1, 1'b0);
        push_event(qwo_pkg::FUNC_CLR, 2'd3, 1'b1, 1'b1);
        push_event(qwo_pkg::FUNC_TICK, 2'd1, 1'b0, 1'b1);
        drain();

        // random phases across scale settings
        write_scale(32'h0000_0000);
        push_random(200);
        drain();

        write_scale(32'h0000_0001);
        push_random(200);
        long_hold_req = 1'b1;
        drain();

        write_scale(32'hFFFF_FFFF);
        push_random(200);
        drain();

        write_scale($urandom);
        push_random(200);
        drain();

        // long runs in both directions on two wheels
        write_scale(32'hFFFF_FFFF);
        for (int k = 0; k < 100; k++) begin
            push_event(qwo_pkg::FUNC_EDGE, 2'd0, 1'b0, 1'b1);
            push_event(qwo_pkg::FUNC_EDGE, 2'd2, 1'b0, 1'b0);
        end
        push_event(qwo_pkg::FUNC_TICK, 2'd0, 1'b0, 1'b0);
        push_event(qwo_pkg::FUNC_TICK, 2'd0, 1'b0, 1'b0);
        drain();

        // closing stretch at full rate
        idle_on = 1'b0;
        write_scale($urandom);
        push_random(200);
        drain();

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
